/* design/rmfr_pkg.sv */
// Package with shared types and constants of the frame receiver.
package rmfr_pkg;

    localparam int RingDepthDefault = 16;
    localparam logic [15:0] NoSender = 16'hffff;
    localparam logic [15:0] CrcPoly = 16'h8408;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_CRC = 3'd1;
    localparam logic [2:0] ST_BAD_HDR = 3'd2;
    localparam logic [2:0] ST_WRONG_DST = 3'd3;
    localparam logic [2:0] ST_SUPPRESSED = 3'd4;

    localparam logic [2:0] REG_OWN_ADDRESS = 3'd0;
    localparam logic [2:0] REG_NO_ACK = 3'd1;
    localparam logic [2:0] REG_ACCEPT_INVALID = 3'd2;
    localparam logic [2:0] REG_PROMISCUOUS = 3'd3;
    localparam logic [2:0] REG_NO_BROADCAST = 3'd4;
    localparam logic [2:0] REG_TABLE_SIZE = 3'd5;
    localparam logic [2:0] REG_CRC_START = 3'd6;

    // Ring search request and answer between the top level and the ring unit.
    typedef struct packed {
        logic        start;
        logic [15:0] sender;
        logic [7:0]  seq;
    } ring_req_t;

    typedef struct packed {
        logic done;
        logic dup;
    } ring_rsp_t;

endpackage

/* design/radio_mac_frame_receiver_top.sv */
// Top level of the radio MAC frame receiver: byte parser, decisions and result register.
//
// Channel   | Direction | Ports                       | Moves
// s_        | in        | s_valid, s_ready, s_rx_byte | one received byte per transfer
// m_        | out       | m_valid, m_ready, m_*       | one frame result per transfer
// cfg       | in        | APB psel..pready            | register writes and reads
//
// A byte that only enters the header does not stall the input; a byte that feeds the
// CRC holds s_ready low while the bit-serial CRC unit shifts it in one bit a cycle.
// At frame end the decision step (S_DEC) runs, then the move into the output
// register (S_OUT). A good frame with ACKs enabled also walks the duplicate
// ring, one entry a cycle; on a miss, pointers left over from a larger
// table_size are first brought below the size in use, then the pair is inserted.
// Reset is synchronous on aresetn and loads the ring with empty senders at once.
// A finished result waits in the output register while the next frame's bytes
// come in; the following result waits at frame end until the first is taken.
module radio_mac_frame_receiver_top import rmfr_pkg::*; #(
    parameter int RingDepth = RingDepthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_kind,
    output logic [2:0]  m_status,
    output logic [15:0] m_source_address,
    output logic [15:0] m_dest_address,
    output logic [7:0]  m_sequence_res,
    output logic        m_deliver,
    output logic        m_ack_due,
    output logic        m_duplicate,
    output logic [7:0]  m_payload_length,
    output logic        m_ack_for_me,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [3:0] {
        S_RUN  = 4'b0001,
        S_DEC  = 4'b0010,
        S_RING = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] own_reg, crc_start_reg;
    logic        no_ack_reg, acc_inv_reg, prom_reg, no_bc_reg;
    logic [4:0]  tsize_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg <= '0;
            no_ack_reg <= 1'b0;
            acc_inv_reg <= 1'b0;
            prom_reg <= 1'b0;
            no_bc_reg <= 1'b0;
            tsize_reg <= 5'd16;
            crc_start_reg <= 16'hffff;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_OWN_ADDRESS:    own_reg <= pwdata[15:0];
                REG_NO_ACK:         no_ack_reg <= pwdata[0];
                REG_ACCEPT_INVALID: acc_inv_reg <= pwdata[0];
                REG_PROMISCUOUS:    prom_reg <= pwdata[0];
                REG_NO_BROADCAST:   no_bc_reg <= pwdata[0];
                REG_TABLE_SIZE:     tsize_reg <= pwdata[4:0];
                REG_CRC_START:      crc_start_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_OWN_ADDRESS:    prdata = {16'd0, own_reg};
            REG_NO_ACK:         prdata = {31'd0, no_ack_reg};
            REG_ACCEPT_INVALID: prdata = {31'd0, acc_inv_reg};
            REG_PROMISCUOUS:    prdata = {31'd0, prom_reg};
            REG_NO_BROADCAST:   prdata = {31'd0, no_bc_reg};
            REG_TABLE_SIZE:     prdata = {27'd0, tsize_reg};
            REG_CRC_START:      prdata = {16'd0, crc_start_reg};
            default:            prdata = '0;
        endcase
    end

    // Frame parsing state.
    logic        recv_reg;
    logic [7:0]  cnt_reg, len_reg;
    logic [15:0] dly_reg;
    logic [7:0]  hdr_reg [5];
    logic        acc;
    logic        crc_load, crc_feed, crc_busy;
    logic [15:0] crc_val;
    ring_req_t   rreq;
    ring_rsp_t   rrsp;
    logic [7:0]  cnt_inc;

    rmfr_crc u_crc (
        .aclk(aclk), .aresetn(aresetn),
        .load(crc_load), .load_value(crc_start_reg),
        .feed(crc_feed), .feed_byte(dly_reg[15:8]),
        .busy(crc_busy), .crc(crc_val)
    );

    rmfr_ring #(.RingDepth(RingDepth)) u_ring (
        .aclk(aclk), .aresetn(aresetn), .table_size(tsize_reg),
        .req(rreq), .rsp(rrsp)
    );

    assign s_ready = (state_reg == S_RUN) && !crc_busy;
    assign acc = s_valid && s_ready;
    assign cnt_inc = cnt_reg + 8'd1;
    assign crc_load = acc && !recv_reg;
    assign crc_feed = acc && recv_reg && (cnt_reg >= 8'd2);

    // Result fields computed in the decision step.
    logic [2:0]  st;
    logic [15:0] src, dst;
    logic [7:0]  seq, plen;
    logic        dlv, ack, kind, forme, ringchk;
    logic [7:0]  L;

    assign L = len_reg;

    always_comb begin
        st = ST_OK; src = '0; dst = '0; seq = '0; plen = '0;
        dlv = 1'b1; ack = 1'b0; kind = 1'b0; forme = 1'b0; ringchk = 1'b0;
        if (L == 8'd3) begin
            kind = 1'b1;
            src = {hdr_reg[0], hdr_reg[1]};
            seq = hdr_reg[2];
            forme = (src == own_reg);
            dlv = 1'b0;
        end else begin
            if (L < 8'd7) begin
                st = ST_BAD_HDR;
            end else begin
                plen = L - 8'd7;
                if (dly_reg != crc_val) begin
                    st = ST_BAD_CRC;
                end else begin
                    src = {hdr_reg[0], hdr_reg[1]};
                    dst = {hdr_reg[2], hdr_reg[3]};
                    seq = hdr_reg[4];
                    if (dst != own_reg && dst != NoSender) st = ST_WRONG_DST;
                end
            end
            if (st == ST_BAD_CRC || st == ST_BAD_HDR) begin
                if (!acc_inv_reg || !prom_reg) dlv = 1'b0;
                else if (no_bc_reg) begin dlv = 1'b0; st = ST_SUPPRESSED; end
            end else if (st == ST_WRONG_DST) begin
                if (!prom_reg) dlv = 1'b0;
                else if (no_bc_reg) begin dlv = 1'b0; st = ST_SUPPRESSED; end
            end
            if (st == ST_OK && !no_ack_reg) begin
                ack = 1'b1;
                ringchk = 1'b1;
            end
        end
    end

    // Output register state.
    logic m_valid_reg;
    logic out_load;

    // Frame end: the last byte was taken and any CRC shifting is over.
    always_comb begin
        state_next = state_reg;
        rreq.start = 1'b0;
        rreq.sender = src;
        rreq.seq = seq;
        unique case (state_reg)
            S_RUN: begin
                if (acc && (!recv_reg ? (s_rx_byte == 8'd0) : (cnt_inc == len_reg))) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (!crc_busy) begin
                    if (ringchk) begin
                        rreq.start = 1'b1;
                        state_next = S_RING;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_RING: if (rrsp.done) state_next = S_OUT;
            S_OUT: if (!m_valid_reg || m_ready) state_next = S_RUN;
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RUN;
            recv_reg <= 1'b0;
            cnt_reg <= '0;
            len_reg <= '0;
            dly_reg <= '0;
            for (int i = 0; i < 5; i++) hdr_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (acc) begin
                if (!recv_reg) begin
                    len_reg <= s_rx_byte;
                    cnt_reg <= '0;
                    dly_reg <= '0;
                    recv_reg <= (s_rx_byte != 8'd0);
                end else begin
                    if (cnt_reg < 8'd5) hdr_reg[cnt_reg[2:0]] <= s_rx_byte;
                    dly_reg <= {dly_reg[7:0], s_rx_byte};
                    cnt_reg <= cnt_inc;
                    if (cnt_inc == len_reg) recv_reg <= 1'b0;
                end
            end
        end
    end

    // Output register, loaded once the decision (and any ring search) is done
    // and the previous result has been taken or is being taken.
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_frame_kind <= kind;
            m_status <= st;
            m_source_address <= src;
            m_dest_address <= dst;
            m_sequence_res <= seq;
            m_deliver <= (ringchk && rrsp.dup) ? 1'b0 : dlv;
            m_ack_due <= ack;
            m_duplicate <= ringchk && rrsp.dup;
            m_payload_length <= plen;
            m_ack_for_me <= forme;
        end
    end
endmodule

/* design/rmfr_crc.sv */
// Bit-serial CRC-CCITT unit, one shift of the reflected polynomial per cycle.
module rmfr_crc import rmfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [15:0] load_value,
    input  logic        feed,
    input  logic [7:0]  feed_byte,
    output logic        busy,
    output logic [15:0] crc
);
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [15:0] mixed;

    assign crc = crc_reg;
    assign busy = busy_reg;

    always_comb begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        mixed = crc_reg ^ {8'd0, feed_byte};
        if (load) begin
            crc_next = load_value;
            busy_next = 1'b0;
        end else if (feed) begin
            // The byte is mixed in and the first shift done at once.
            crc_next = mixed[0] ? ((mixed >> 1) ^ CrcPoly) : (mixed >> 1);
            cnt_next = 3'd1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CrcPoly) : (crc_reg >> 1);
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= 16'hffff;
            cnt_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
        end
    end
endmodule

/* design/rmfr_ring.sv */
// Duplicate-suppression ring with a sequential one-entry-per-cycle search.
module rmfr_ring import rmfr_pkg::*; #(
    parameter int RingDepth = RingDepthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [4:0]  table_size,
    input  ring_req_t   req,
    output ring_rsp_t   rsp
);
    localparam int IW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
    localparam int CW = $clog2(RingDepth + 1);

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_SCAN = 4'b0010,
        R_MOD  = 4'b0100,
        R_INS  = 4'b1000
    } rstate_t;

    rstate_t state_reg, state_next;
    logic [15:0] snd_reg [RingDepth];
    logic [7:0]  sq_reg [RingDepth];
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] old_reg, old_next, new_reg, new_next;
    logic [15:0] key_snd_reg;
    logic [7:0]  key_sq_reg;
    logic [CW-1:0] size_use;
    logic [CW-1:0] n_inc;
    logic        wr_en;
    logic [IW-1:0] wr_idx;
    logic        done_reg, dup_reg, done_next, dup_next;
    logic [15:0] cur_snd;
    logic [7:0]  cur_sq;

    assign rsp.done = done_reg;
    assign rsp.dup = dup_reg;

    always_comb begin
        if (table_size == 5'd0) begin
            size_use = CW'(1);
        end else if (32'(table_size) > RingDepth) begin
            size_use = CW'(RingDepth);
        end else begin
            size_use = CW'(table_size);
        end
        n_inc = (new_reg + CW'(1) == size_use) ? '0 : new_reg + CW'(1);
        cur_snd = snd_reg[idx_reg[IW-1:0]];
        cur_sq = sq_reg[idx_reg[IW-1:0]];
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        old_next = old_reg;
        new_next = new_reg;
        wr_en = 1'b0;
        wr_idx = '0;
        done_next = 1'b0;
        dup_next = dup_reg;
        unique case (state_reg)
            R_IDLE: begin
                if (req.start) begin
                    idx_next = '0;
                    state_next = R_SCAN;
                end
            end
            R_SCAN: begin
                if (cur_snd != NoSender && cur_snd == key_snd_reg) begin
                    dup_next = (cur_sq == key_sq_reg);
                    wr_en = !(cur_sq == key_sq_reg);
                    wr_idx = idx_reg[IW-1:0];
                    done_next = 1'b1;
                    state_next = R_IDLE;
                end else if (idx_reg + CW'(1) >= size_use) begin
                    state_next = R_MOD;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            R_MOD: begin
                // Pointers left over from a larger table size are brought
                // below the size in use by one subtraction per cycle.
                if (old_reg >= size_use) begin
                    old_next = old_reg - size_use;
                end else if (new_reg >= size_use) begin
                    new_next = new_reg - size_use;
                end else begin
                    state_next = R_INS;
                end
            end
            R_INS: begin
                dup_next = 1'b0;
                wr_en = 1'b1;
                done_next = 1'b1;
                state_next = R_IDLE;
                if (n_inc == old_reg) begin
                    wr_idx = old_reg[IW-1:0];
                    old_next = (old_reg + CW'(1) == size_use) ? '0 : old_reg + CW'(1);
                end else begin
                    wr_idx = n_inc[IW-1:0];
                    new_next = n_inc;
                end
            end
            default: state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            old_reg <= '0;
            new_reg <= '0;
            idx_reg <= '0;
            done_reg <= 1'b0;
            dup_reg <= 1'b0;
            for (int i = 0; i < RingDepth; i++) begin
                snd_reg[i] <= NoSender;
                sq_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            old_reg <= old_next;
            new_reg <= new_next;
            idx_reg <= idx_next;
            done_reg <= done_next;
            dup_reg <= dup_next;
            if (wr_en) begin
                snd_reg[wr_idx] <= key_snd_reg;
                sq_reg[wr_idx] <= key_sq_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            key_snd_reg <= req.sender;
            key_sq_reg <= req.seq;
        end
    end
endmodule

/* dv/radio_mac_frame_receiver_top_tb.sv */
// Self-checking testbench for the radio MAC frame receiver top level.
module radio_mac_frame_receiver_top_tb;
    import rmfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected frame result, one member for each result port.
    typedef struct {
        logic        kind;
        logic [2:0]  status;
        logic [15:0] src;
        logic [15:0] dst;
        logic [7:0]  seq;
        logic        deliver;
        logic        ack_due;
        logic        dup;
        logic [7:0]  plen;
        logic        ack_me;
    } frame_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_frame_kind;
    logic [2:0]  m_status;
    logic [15:0] m_source_address;
    logic [15:0] m_dest_address;
    logic [7:0]  m_sequence_res;
    logic        m_deliver;
    logic        m_ack_due;
    logic        m_duplicate;
    logic [7:0]  m_payload_length;
    logic        m_ack_for_me;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    radio_mac_frame_receiver_top dut (.*);

    // Predictor copy of the configuration registers.
    logic [15:0] cfg_own;
    logic        cfg_no_ack;
    logic        cfg_accept_invalid;
    logic        cfg_promisc;
    logic        cfg_no_bcast;
    logic [4:0]  cfg_table_size;
    logic [15:0] cfg_crc_start;

    // Predictor copy of the parser state and the duplicate ring.
    logic        rx_busy;
    logic [7:0]  rx_count;
    logic [7:0]  rx_length;
    logic [15:0] rx_crc;
    logic [15:0] rx_tail;
    logic [7:0]  rx_header [5];
    logic [15:0] seen_sender [RingDepthDefault];
    logic [7:0]  seen_seq [RingDepthDefault];
    int unsigned seen_oldest;
    int unsigned seen_newest;

    logic [7:0]    byte_queue [$];
    frame_result_t expected_frames [$];
    int            error_count;
    int            frames_seen;
    logic          cfg_busy;
    logic          in_taken;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Bit-serial CRC-CCITT step over one byte, reflected polynomial.
    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
        end
        return v;
    endfunction

    // Searches the ring for the sender and inserts or refreshes the pair.
    // Returns 1 when the pair is a retransmission.
    function automatic logic dedup_lookup(input logic [15:0] src, input logic [7:0] seq);
        int unsigned sz;
        sz = cfg_table_size;
        if (sz == 0) begin
            sz = 1;
        end
        if (sz > RingDepthDefault) begin
            sz = RingDepthDefault;
        end
        for (int unsigned i = 0; i < sz; i++) begin
            if (seen_sender[i] != NoSender && seen_sender[i] == src) begin
                if (seen_seq[i] == seq) begin
                    return 1'b1;
                end
                seen_seq[i] = seq;
                return 1'b0;
            end
        end
        seen_oldest = seen_oldest % sz;
        seen_newest = seen_newest % sz;
        if ((seen_newest + 1) % sz == seen_oldest) begin
            seen_sender[seen_oldest] = src;
            seen_seq[seen_oldest] = seq;
            seen_oldest = (seen_oldest + 1) % sz;
        end else begin
            seen_newest = (seen_newest + 1) % sz;
            seen_sender[seen_newest] = src;
            seen_seq[seen_newest] = seq;
        end
        return 1'b0;
    endfunction

    // Works out the result of the frame that just completed.
    function automatic frame_result_t decide_frame();
        frame_result_t r;
        r = '{default: '0};
        r.deliver = 1'b1;
        if (rx_length == 8'd3) begin
            r = '{default: '0};
            r.kind = 1'b1;
            r.src = {rx_header[0], rx_header[1]};
            r.seq = rx_header[2];
            r.ack_me = (r.src == cfg_own);
            return r;
        end
        if (rx_length < 8'd7) begin
            r.status = ST_BAD_HDR;
        end else begin
            r.plen = rx_length - 8'd7;
            if (rx_tail != rx_crc) begin
                r.status = ST_BAD_CRC;
            end else begin
                r.src = {rx_header[0], rx_header[1]};
                r.dst = {rx_header[2], rx_header[3]};
                r.seq = rx_header[4];
                if (r.dst != cfg_own && r.dst != NoSender) begin
                    r.status = ST_WRONG_DST;
                end
            end
        end
        if (r.status == ST_BAD_CRC || r.status == ST_BAD_HDR) begin
            if (!cfg_accept_invalid || !cfg_promisc) begin
                r.deliver = 1'b0;
            end else if (cfg_no_bcast) begin
                r.deliver = 1'b0;
                r.status = ST_SUPPRESSED;
            end
        end else if (r.status == ST_WRONG_DST) begin
            if (!cfg_promisc) begin
                r.deliver = 1'b0;
            end else if (cfg_no_bcast) begin
                r.deliver = 1'b0;
                r.status = ST_SUPPRESSED;
            end
        end
        if (r.status == ST_OK && !cfg_no_ack) begin
            r.ack_due = 1'b1;
            if (dedup_lookup(r.src, r.seq)) begin
                r.dup = 1'b1;
                r.deliver = 1'b0;
            end
        end
        return r;
    endfunction

    // Advances the predictor by one accepted byte.
    function automatic void absorb_byte(input logic [7:0] b);
        if (!rx_busy) begin
            rx_length = b;
            rx_count = 0;
            rx_crc = cfg_crc_start;
            rx_tail = 0;
            if (b != 0) begin
                rx_busy = 1'b1;
            end else begin
                expected_frames.push_back(decide_frame());
            end
            return;
        end
        if (rx_count < 5) begin
            rx_header[rx_count] = b;
        end
        if (rx_count >= 2) begin
            rx_crc = crc_ccitt_byte(rx_crc, rx_tail[15:8]);
        end
        rx_tail = {rx_tail[7:0], b};
        rx_count++;
        if (rx_count == rx_length) begin
            rx_busy = 1'b0;
            expected_frames.push_back(decide_frame());
        end
    endfunction

    // Driver: takes bytes from the queue with a random gap between one byte and the next.
    int unsigned send_gap;
    always @(negedge aclk) begin
        if (!aresetn || cfg_busy) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // Hold the byte until it is taken.
        end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            s_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
            s_rx_byte <= byte_queue.pop_front();
            s_valid <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // A transfer on the input side feeds the predictor at the same edge.
    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            absorb_byte(s_rx_byte);
        end
    end

    // Receiver stalls: ready drops for a random number of cycles after each result.
    int unsigned recv_stall;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else if (m_valid && m_ready) begin
            m_ready <= 1'b0;
            recv_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        end else if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: each result transfer is checked against the oldest prediction.
    always @(posedge aclk) begin
        frame_result_t e;
        if (aresetn && m_valid && m_ready) begin
            frames_seen++;
            if (expected_frames.size() == 0) begin
                $error("result transfer with no frame expected");
                error_count++;
            end else begin
                e = expected_frames.pop_front();
                if (m_frame_kind !== e.kind) begin
                    $error("frame_kind exp %0d got %0d", e.kind, m_frame_kind);
                    error_count++;
                end
                if (m_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_status);
                    error_count++;
                end
                if (m_source_address !== e.src) begin
                    $error("source_address exp %h got %h", e.src, m_source_address);
                    error_count++;
                end
                if (m_dest_address !== e.dst) begin
                    $error("dest_address exp %h got %h", e.dst, m_dest_address);
                    error_count++;
                end
                if (m_sequence_res !== e.seq) begin
                    $error("sequence_res exp %h got %h", e.seq, m_sequence_res);
                    error_count++;
                end
                if (m_deliver !== e.deliver) begin
                    $error("deliver exp %0d got %0d", e.deliver, m_deliver);
                    error_count++;
                end
                if (m_ack_due !== e.ack_due) begin
                    $error("ack_due exp %0d got %0d", e.ack_due, m_ack_due);
                    error_count++;
                end
                if (m_duplicate !== e.dup) begin
                    $error("duplicate exp %0d got %0d", e.dup, m_duplicate);
                    error_count++;
                end
                if (m_payload_length !== e.plen) begin
                    $error("payload_length exp %0d got %0d", e.plen, m_payload_length);
                    error_count++;
                end
                if (m_ack_for_me !== e.ack_me) begin
                    $error("ack_for_me exp %0d got %0d", e.ack_me, m_ack_for_me);
                    error_count++;
                end
            end
        end
    end

    // One APB write: setup then access, changes driven on the falling edge.
    // The predictor copy is updated at the edge that writes the register.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_OWN_ADDRESS: cfg_own = value[15:0];
            REG_NO_ACK: cfg_no_ack = value[0];
            REG_ACCEPT_INVALID: cfg_accept_invalid = value[0];
            REG_PROMISCUOUS: cfg_promisc = value[0];
            REG_NO_BROADCAST: cfg_no_bcast = value[0];
            REG_TABLE_SIZE: cfg_table_size = value[4:0];
            REG_CRC_START: cfg_crc_start = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Queues one data frame. A good CRC is appended unless a corruption is asked for.
    task automatic queue_data_frame(input logic [15:0] src, input logic [15:0] dst,
                                    input logic [7:0] seq, input int unsigned plen,
                                    input logic corrupt);
        logic [7:0]  body [$];
        logic [15:0] crc;
        body = '{src[15:8], src[7:0], dst[15:8], dst[7:0], seq};
        for (int unsigned i = 0; i < plen; i++) begin
            body.push_back(8'($urandom));
        end
        crc = cfg_crc_start;
        foreach (body[i]) begin
            crc = crc_ccitt_byte(crc, body[i]);
        end
        if (corrupt) begin
            crc ^= 16'(1 << $urandom_range(0, 15));
        end
        byte_queue.push_back(8'(plen + 7));
        foreach (body[i]) begin
            byte_queue.push_back(body[i]);
        end
        byte_queue.push_back(crc[15:8]);
        byte_queue.push_back(crc[7:0]);
    endtask

    task automatic queue_ack_frame(input logic [15:0] src, input logic [7:0] seq);
        byte_queue.push_back(8'd3);
        byte_queue.push_back(src[15:8]);
        byte_queue.push_back(src[7:0]);
        byte_queue.push_back(seq);
    endtask

    // Waits until all bytes went in and every result came out, then lets the
    // block settle.
    task automatic drain();
        int unsigned guard;
        guard = 0;
        while ((byte_queue.size() != 0 || s_valid || expected_frames.size() != 0)
               && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);
    endtask

    // Random frame from a small pool of senders so that retransmissions occur.
    task automatic queue_random_frame();
        int unsigned pick;
        logic [15:0] src;
        logic [15:0] dst;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        src = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        if ($urandom_range(0, 9) == 0) begin
            src = NoSender;
        end
        case ($urandom_range(0, 3))
            0: dst = NoSender;
            1: dst = 16'($urandom);
            default: dst = cfg_own;
        endcase
        b = 8'($urandom_range(0, 3));
        if (pick < 70) begin
            queue_data_frame(src, dst, b, $urandom_range(0, 6), 1'b0);
        end else if (pick < 78) begin
            queue_data_frame(src, dst, 8'($urandom), $urandom_range(0, 6), 1'b1);
        end else if (pick < 88) begin
            queue_ack_frame(($urandom_range(0, 1) != 0) ? cfg_own : 16'($urandom),
                            8'($urandom));
        end else if (pick < 96) begin
            // Short header frame of random length below seven.
            b = 8'($urandom_range(0, 6));
            if (b == 8'd3) begin
                b = 8'd5;
            end
            byte_queue.push_back(b);
            for (int unsigned i = 0; i < b; i++) begin
                byte_queue.push_back(8'($urandom));
            end
        end else begin
            queue_data_frame(16'($urandom), 16'($urandom), 8'($urandom),
                             $urandom_range(7, 20), 1'($urandom));
        end
    endtask

    initial begin
        logic [7:0] long_len;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_busy = 1'b1;
        in_taken = 1'b0;
        error_count = 0;
        frames_seen = 0;
        send_gap = 0;
        cfg_own = '0;
        cfg_no_ack = 1'b0;
        cfg_accept_invalid = 1'b0;
        cfg_promisc = 1'b0;
        cfg_no_bcast = 1'b0;
        cfg_table_size = 5'd16;
        cfg_crc_start = 16'hffff;
        rx_busy = 1'b0;
        rx_count = '0;
        rx_length = '0;
        rx_crc = 16'hffff;
        rx_tail = '0;
        foreach (rx_header[i]) begin
            rx_header[i] = '0;
        end
        for (int i = 0; i < RingDepthDefault; i++) begin
            seen_sender[i] = NoSender;
            seen_seq[i] = '0;
        end
        seen_oldest = 0;
        seen_newest = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings.
        apb_write(REG_OWN_ADDRESS, 32'h0000_1234);
        cfg_busy = 1'b0;
        byte_queue.push_back(8'd0);
        queue_ack_frame(16'h1234, 8'hff);
        queue_ack_frame(16'hffff, 8'h00);
        queue_data_frame(16'h0001, 16'h1234, 8'h07, 0, 1'b0);
        queue_data_frame(16'h0001, 16'h1234, 8'h07, 0, 1'b0);
        queue_data_frame(16'h0001, 16'h1234, 8'h08, 2, 1'b0);
        queue_data_frame(16'hffff, 16'hffff, 8'hff, 1, 1'b0);
        queue_data_frame(16'hffff, 16'hffff, 8'hff, 1, 1'b0);
        queue_data_frame(16'h0000, 16'h5555, 8'h00, 3, 1'b0);
        queue_data_frame(16'h00aa, 16'h1234, 8'h55, 4, 1'b1);
        byte_queue.push_back(8'd6);
        repeat (6) byte_queue.push_back(8'hff);
        byte_queue.push_back(8'd1);
        byte_queue.push_back(8'h00);
        // A length of 255 exercises the largest length byte with a bad CRC.
        long_len = 8'd255;
        byte_queue.push_back(long_len);
        for (int i = 0; i < 255; i++) begin
            byte_queue.push_back(8'($urandom));
        end
        drain();

        // Phases through the register settings, extremes among them.
        for (int phase = 0; phase < 10; phase++) begin
            cfg_busy = 1'b1;
            apb_write(REG_OWN_ADDRESS, (phase == 1) ? 32'hffff : (phase == 2) ? 32'h0 :
                                       32'($urandom_range(0, 5)));
            apb_write(REG_NO_ACK, 32'(phase % 4 == 3));
            apb_write(REG_ACCEPT_INVALID, 32'(phase[0]));
            apb_write(REG_PROMISCUOUS, 32'(phase[1] | phase[0]));
            apb_write(REG_NO_BROADCAST, 32'(phase == 3 || phase == 6 || phase == 9));
            case (phase)
                0: apb_write(REG_TABLE_SIZE, 1);
                1: apb_write(REG_TABLE_SIZE, 0);
                2: apb_write(REG_TABLE_SIZE, 31);
                3: apb_write(REG_TABLE_SIZE, 16);
                default: apb_write(REG_TABLE_SIZE, $urandom_range(1, 6));
            endcase
            case (phase)
                0: apb_write(REG_CRC_START, 32'h0000);
                1: apb_write(REG_CRC_START, 32'hffff);
                default: apb_write(REG_CRC_START, 32'($urandom_range(0, 65535)));
            endcase
            cfg_busy = 1'b0;
            for (int n = 0; n < 4; n++) begin
                queue_random_frame();
            end
            // Occasionally a stray length byte alone breaks into the next frame.
            if ($urandom_range(0, 1) != 0) begin
                byte_queue.push_back(8'($urandom_range(8, 12)));
                for (int n = 0; n < 2; n++) begin
                    queue_random_frame();
                end
            end
            drain();
            // A broken tail may leave the parser mid-frame; finish it with zeros.
            while (rx_busy) begin
                byte_queue.push_back(8'h00);
                drain();
            end
        end

        if (error_count == 0 && expected_frames.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
